// ===== rtl/core/hlc_pkg.sv =====
`timescale 1ns / 1ps

package hlc_pkg;

	// field widths
	localparam int PHYS_W    = 64;
	localparam int LOGICAL_W = 32;
	localparam int DRIFT_W   = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// default width of the logical counter
	localparam int LOGICAL_BITS_DEF = 32;

	// command codes
	localparam logic CMD_LOCAL = 1'b0;
	localparam logic CMD_RECV  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HLC_ENABLE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT = 1'b1;

	// configuration reset values
	localparam logic               HLC_ENABLE_RST  = 1'b1;
	localparam logic [DRIFT_W-1:0] DRIFT_LIMIT_RST = 32'd1000;

	// input word
	typedef struct packed {
		logic                 cmd;
		logic [PHYS_W-1:0]    sync_time;
		logic [PHYS_W-1:0]    recv_physical;
		logic [LOGICAL_W-1:0] recv_logical;
	} hlc_in_t;

	// result word
	typedef struct packed {
		logic [PHYS_W-1:0]    out_physical;
		logic [LOGICAL_W-1:0] out_logical;
		logic                 drift_rejected;
	} hlc_out_t;

endpackage

// ===== rtl/core/hybrid_logical_clock_unit.sv =====
`timescale 1ns / 1ps

// channel   | signals                              | direction
// ----------+--------------------------------------+----------
// item      | item_valid, item_stall, item         | in
// result    | result_valid, result_stall, result   | out
// config    | cfg_valid, cfg_ready, cfg_index/data | in
//
// one word per clock while result_stall is low; an accepted word goes into the
// input register, then through the timestamp logic into the result register,
// where result_valid rises (a result stall can hold it in the input register).
// the stored physical part and counter update (while enabled) as a word enters
// the result register, so the next word sees them without a bubble.
// arst_n clears the pipeline valids and the clock state, and loads the
// register defaults (enable 1, drift limit 1000).
// result_stall holds the result register and backs up into item_stall only
// while the input register is full; config is always ready.

module hybrid_logical_clock_unit #(
	parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  hlc_pkg::hlc_in_t                     item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output hlc_pkg::hlc_out_t                    result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hlc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hlc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import hlc_pkg::*;

	// counter width, capped at the field width
	localparam int CW = (LOGICAL_BITS > LOGICAL_W) ? LOGICAL_W : LOGICAL_BITS;
	localparam logic [CW-1:0] LMax = '1;

	logic                 hlc_enable_q;
	logic [DRIFT_W-1:0]   drift_limit_q;
	logic [PHYS_W-1:0]    last_physical_q;
	logic [CW-1:0]        logical_count_q;

	logic                 valid_s1;
	hlc_in_t              item_s1;
	logic                 valid_s2;
	hlc_out_t             result_s2;

	logic                 adv_s1;
	logic                 accept;

	logic [CW-1:0]        rlog;
	logic [CW-1:0]        lg_base;
	logic [CW-1:0]        lg_inc;
	logic [CW-1:0]        lg;
	logic [PHYS_W-1:0]    phys;
	logic                 rej;
	logic                 local_ahead;
	logic                 recv_behind;
	logic [PHYS_W-1:0]    lead;
	logic                 over_drift;
	hlc_out_t             res_d;

	// handshake
	assign adv_s1     = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlc_enable_q  <= HLC_ENABLE_RST;
			drift_limit_q <= DRIFT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HLC_ENABLE:  hlc_enable_q  <= cfg_data[0];
				CFG_DRIFT_LIMIT: drift_limit_q <= cfg_data[DRIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (!result_stall)
				valid_s2 <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	// received counter clamped to the counter range
	always_comb begin
		if (item_s1.recv_logical > LOGICAL_W'(LMax))
			rlog = LMax;
		else
			rlog = item_s1.recv_logical[CW-1:0];
	end

	// compares on the physical parts
	assign local_ahead = item_s1.sync_time > last_physical_q;
	assign recv_behind = item_s1.sync_time >= item_s1.recv_physical;
	assign lead        = item_s1.recv_physical - item_s1.sync_time;
	assign over_drift  = lead > PHYS_W'(drift_limit_q);

	// timestamp merge
	always_comb begin
		lg_base = logical_count_q;
		phys    = last_physical_q;
		rej     = 1'b0;
		if (item_s1.cmd == CMD_LOCAL) begin
			if (local_ahead)
				phys = item_s1.sync_time;
		end else if (recv_behind) begin
			phys    = item_s1.sync_time;
			lg_base = (logical_count_q > rlog) ? logical_count_q : rlog;
		end else begin
			lg_base = rlog;
			if (over_drift) begin
				phys = item_s1.sync_time;
				rej  = 1'b1;
			end else begin
				phys = item_s1.recv_physical;
			end
		end
		lg_inc = (lg_base == LMax) ? LMax : lg_base + 1'b1;
		if (item_s1.cmd == CMD_LOCAL && local_ahead)
			lg = '0;
		else
			lg = lg_inc;
	end

	// result word, plain time when disabled
	always_comb begin
		if (hlc_enable_q) begin
			res_d.out_physical   = phys;
			res_d.out_logical    = LOGICAL_W'(lg);
			res_d.drift_rejected = rej;
		end else begin
			res_d.out_physical   = item_s1.sync_time;
			res_d.out_logical    = '0;
			res_d.drift_rejected = 1'b0;
		end
	end

	// clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_physical_q <= '0;
			logical_count_q <= '0;
		end else if (adv_s1 && hlc_enable_q) begin
			last_physical_q <= phys;
			logical_count_q <= lg;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s1)
			result_s2 <= res_d;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef ASSERT_OFF
	// disabled words leave the clock state alone
	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !hlc_enable_q) |=> ($stable(last_physical_q) && $stable(logical_count_q)))
		else $error("clock state changed while disabled");

	// issued stamp matches the stored state
	a_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && hlc_enable_q) |=> (last_physical_q == result_s2.out_physical &&
			LOGICAL_W'(logical_count_q) == result_s2.out_logical))
		else $error("stored state differs from issued stamp");

	// a rejected receive still bumps the counter
	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.drift_rejected) |-> (result_s2.out_logical != '0))
		else $error("drift reject with zero counter");

	// input stall only with a full input register
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("stall with empty input register");
`endif

endmodule

// ===== verif/tb_hybrid_logical_clock_unit.sv =====
`timescale 1ns / 1ps

module tb_hybrid_logical_clock_unit;

	import hlc_pkg::*;

	localparam int LOGICAL_BITS = LOGICAL_BITS_DEF;
	localparam logic [LOGICAL_W-1:0] LOGICAL_MAX =
		(LOGICAL_BITS >= 32) ? '1 : LOGICAL_W'((64'd1 << LOGICAL_BITS) - 64'd1);
	localparam logic [PHYS_W-1:0] PHYS_MAX = '1;

	// one line of the directed plan: a register write or an item word
	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		hlc_in_t               word;
		logic                  typed;
		hlc_out_t              stamp;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	hlc_in_t               item;
	logic                  result_valid;
	logic                  result_stall;
	hlc_out_t              result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// clock model state and register copies
	logic [PHYS_W-1:0]    held_physical;
	logic [LOGICAL_W-1:0] held_count;
	logic                 enable_cfg;
	logic [DRIFT_W-1:0]   drift_cfg;

	hlc_out_t    stamps_due[$];
	plan_row_t   directed_plan[$];
	logic [63:0] walk_time;
	bit          tx_quiet;
	bit          rx_quiet;
	int unsigned err_count;

	hybrid_logical_clock_unit #(
		.LOGICAL_BITS(LOGICAL_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// saturating counter increment
	function automatic logic [LOGICAL_W-1:0] bump_count(logic [LOGICAL_W-1:0] c);
		return (c >= LOGICAL_MAX) ? LOGICAL_MAX : c + 1'b1;
	endfunction

	function automatic logic [LOGICAL_W-1:0] clip_count(logic [LOGICAL_W-1:0] c);
		return (c > LOGICAL_MAX) ? LOGICAL_MAX : c;
	endfunction

	// timestamp the unit should issue for an accepted word; advances the clock state while enabled
	function automatic hlc_out_t next_stamp(hlc_in_t w);
		hlc_out_t             s;
		logic [LOGICAL_W-1:0] rlog;
		logic [LOGICAL_W-1:0] own;
		s = '0;
		rlog = clip_count(w.recv_logical);
		own = clip_count(held_count);
		if (!enable_cfg) begin
			s.out_physical = w.sync_time;
			return s;
		end
		if (w.cmd == CMD_LOCAL) begin
			if (w.sync_time > held_physical) begin
				s.out_physical = w.sync_time;
				s.out_logical = '0;
			end else begin
				s.out_physical = held_physical;
				s.out_logical = bump_count(own);
			end
		end else if (w.sync_time >= w.recv_physical) begin
			s.out_physical = w.sync_time;
			s.out_logical = bump_count((own > rlog) ? own : rlog);
		end else begin
			s.out_physical = w.recv_physical;
			s.out_logical = bump_count(rlog);
			// remote too far ahead: keep local time and flag it
			if (w.recv_physical - w.sync_time > {32'd0, drift_cfg}) begin
				s.out_physical = w.sync_time;
				s.drift_rejected = 1'b1;
			end
		end
		held_physical = s.out_physical;
		held_count = s.out_logical;
		return s;
	endfunction

	function automatic void plan_word(logic cmd, logic [63:0] t, logic [63:0] rp,
			logic [31:0] rl, logic typed = 1'b0, logic [63:0] ph = '0,
			logic [31:0] lg = '0, logic rej = 1'b0);
		plan_row_t r;
		r = '{default: '0};
		r.word.cmd = cmd;
		r.word.sync_time = t;
		r.word.recv_physical = rp;
		r.word.recv_logical = rl;
		r.typed = typed;
		r.stamp.out_physical = ph;
		r.stamp.out_logical = lg;
		r.stamp.drift_rejected = rej;
		directed_plan.insert(directed_plan.size(), r);
	endfunction

	function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		directed_plan.insert(directed_plan.size(), r);
	endfunction

	// random word: local time mostly creeps along, remote lead often sits at or just past the drift limit
	function automatic hlc_in_t random_word();
		hlc_in_t     w;
		logic [63:0] lead;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		w.cmd = $urandom_range(0, 1) ? CMD_RECV : CMD_LOCAL;
		case ($urandom_range(0, 9))
			0: walk_time = walk_time - 64'($urandom_range(0, 50));
			1, 2: walk_time = walk_time;
			default: walk_time = walk_time + 64'($urandom_range(0, 3));
		endcase
		w.sync_time = (pick < 8) ? {$urandom, $urandom} : walk_time;
		case ($urandom_range(0, 7))
			0: lead = 64'd0 - 64'($urandom_range(0, 20));
			1: lead = '0;
			2: lead = 64'($urandom_range(1, 20));
			3: lead = 64'(drift_cfg);
			4: lead = 64'(drift_cfg) + 64'd1;
			5: lead = {$urandom, $urandom};
			default: lead = 64'($urandom_range(0, drift_cfg));
		endcase
		w.recv_physical = w.sync_time + lead;
		case ($urandom_range(0, 3))
			0: w.recv_logical = $urandom_range(0, 15);
			1: w.recv_logical = held_count + $urandom_range(0, 3);
			2: w.recv_logical = LOGICAL_MAX - $urandom_range(0, 3);
			default: w.recv_logical = $urandom;
		endcase
		return w;
	endfunction

	// offer one word, hold it until taken, then log its expected stamp
	task automatic send_word(hlc_in_t w, logic typed, hlc_out_t stamp);
		int unsigned gap;
		hlc_out_t    s;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		s = next_stamp(w);
		stamps_due.insert(stamps_due.size(), typed ? stamp : s);
	endtask

	// drain: stop sending and wait for every outstanding stamp
	task automatic settle();
		item_valid <= 1'b0;
		while (stamps_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write, then cfg_valid low again before returning
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_HLC_ENABLE)
			enable_cfg = data[0];
		else
			drift_cfg = data;
		@(posedge clk);
	endtask

	task automatic run_phase(logic en, logic [DRIFT_W-1:0] drift, int unsigned count);
		settle();
		write_reg(CFG_HLC_ENABLE, {31'd0, en});
		write_reg(CFG_DRIFT_LIMIT, drift);
		repeat (count) begin
			if ($urandom_range(0, 99) == 0)
				settle();
			send_word(random_word(), 1'b0, '0);
		end
	endtask

	// result side: random stall after some words, compare against the oldest stamp
	initial begin : result_side
		hlc_out_t    want;
		int unsigned hold;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (stamps_due.size() == 0) begin
					$error("result word with no stamp pending");
					err_count++;
				end else begin
					want = stamps_due.pop_front();
					if (result.out_physical !== want.out_physical) begin
						$error("out_physical: expected %0h, got %0h",
							want.out_physical, result.out_physical);
						err_count++;
					end
					if (result.out_logical !== want.out_logical) begin
						$error("out_logical: expected %0h, got %0h",
							want.out_logical, result.out_logical);
						err_count++;
					end
					if (result.drift_rejected !== want.drift_rejected) begin
						$error("drift_rejected: expected %0b, got %0b",
							want.drift_rejected, result.drift_rejected);
						err_count++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
				hold = rx_quiet ? 0 : $urandom_range(0, 18);
				if (hold != 0) begin
					result_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					result_stall <= 1'b0;
				end
			end
		end
	end

	// stimulus
	initial begin : item_side
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_count = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		held_physical = '0;
		held_count = '0;
		enable_cfg = HLC_ENABLE_RST;
		drift_cfg = DRIFT_LIMIT_RST;
		walk_time = {16'd0, $urandom, 16'($urandom)};

		// after reset: stored time 0, counter 0
		plan_word(CMD_LOCAL, 0, PHYS_MAX, '1, 1, 0, 1, 0);
		plan_word(CMD_LOCAL, 0, 0, 0, 1, 0, 2, 0);
		plan_word(CMD_LOCAL, 100, 0, 0, 1, 100, 0, 0);
		plan_word(CMD_RECV, 100, 50, 7);
		// counter saturation through a received maximum
		plan_word(CMD_RECV, 100, 100, LOGICAL_MAX, 1, 100, LOGICAL_MAX, 0);
		plan_word(CMD_LOCAL, 50, 0, 0);
		// lead exactly at the drift limit, then one past it
		plan_word(CMD_RECV, 200, 1200, 3);
		plan_word(CMD_RECV, 200, 1201, 3, 1, 200, 4, 1);
		plan_word(CMD_LOCAL, 150, PHYS_MAX, 0);
		// time extremes
		plan_word(CMD_RECV, PHYS_MAX, PHYS_MAX, 0);
		plan_word(CMD_LOCAL, PHYS_MAX, 0, 0);
		plan_word(CMD_LOCAL, 0, 0, 0);
		// physical step back to zero on a rejected remote stamp
		plan_word(CMD_RECV, 0, PHYS_MAX, '1, 1, 0, LOGICAL_MAX, 1);
		plan_word(CMD_RECV, 0, 0, 0, 1, 0, LOGICAL_MAX, 0);
		plan_word(CMD_LOCAL, 1, 0, 0, 1, 1, 0, 0);
		// disabled: plain time, state kept
		plan_cfg(CFG_HLC_ENABLE, 0);
		plan_word(CMD_RECV, 5, 99999, 9, 1, 5, 0, 0);
		plan_word(CMD_LOCAL, PHYS_MAX, PHYS_MAX, '1, 1, PHYS_MAX, 0, 0);
		plan_cfg(CFG_HLC_ENABLE, 1);
		plan_word(CMD_LOCAL, 1, 0, 0, 1, 1, 1, 0);
		// zero drift limit
		plan_cfg(CFG_DRIFT_LIMIT, 0);
		plan_word(CMD_RECV, 10, 11, 2, 1, 10, 3, 1);
		plan_word(CMD_RECV, 10, 10, 2);
		// widest drift limit
		plan_cfg(CFG_DRIFT_LIMIT, '1);
		plan_word(CMD_RECV, 0, 64'hFFFF_FFFF, 0);
		plan_word(CMD_RECV, 0, 64'h1_0000_0000, 0, 1, 0, 1, 1);
		plan_cfg(CFG_DRIFT_LIMIT, DRIFT_LIMIT_RST);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				settle();
				write_reg(directed_plan[i].idx, directed_plan[i].data);
			end else begin
				send_word(directed_plan[i].word, directed_plan[i].typed,
					directed_plan[i].stamp);
			end
		end

		// random phases across register settings
		run_phase(1'b1, DRIFT_LIMIT_RST, 180);
		run_phase(1'b1, DRIFT_W'($urandom_range(0, 30)), 180);
		run_phase(1'b0, $urandom, 60);
		run_phase(1'b1, '1, 150);
		run_phase(1'b1, $urandom, 150);

		settle();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/hlc_pkg.sv
rtl/core/hybrid_logical_clock_unit.sv
verif/tb_hybrid_logical_clock_unit.sv
